/* src/assert_macros.svh */
// Assertion helpers used by the top-level RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* src/mdwq_pkg.sv */
package mdwq_pkg;

    localparam int ID_W  = 8;
    localparam int LVL_W = 4;

    typedef logic [1:0] op_t;

    localparam op_t OP_ENQ  = 2'd0;
    localparam op_t OP_DEQ  = 2'd1;
    localparam op_t OP_MARK = 2'd2;

    typedef struct packed {
        op_t              op;
        logic             id_ok;
        logic [ID_W-1:0]  id;
        logic [LVL_W-1:0] lvl;
    } cmd_t;

    typedef struct packed {
        logic            accepted;
        logic [ID_W-1:0] item;
        logic            retired;
        logic            empty;
    } res_t;

endpackage

/* src/mdwq_front.sv */
module mdwq_front
    import mdwq_pkg::*;
#(
    parameter int ITEM_COUNT  = 256,
    parameter int LEVEL_COUNT = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  op_t              op,
    input  logic [ID_W-1:0]  item_id,
    input  logic [LVL_W-1:0] level,
    input  logic             clearing,
    input  logic             cmd_pop,
    output logic             busy,
    output logic             cmd_valid,
    output cmd_t             cmd
);

    logic [1:0] cnt_reg, cnt_next;
    logic       wp_reg, wp_next;
    logic       rp_reg, rp_next;
    cmd_t       q_reg [2];
    cmd_t       new_cmd;
    logic       push;

    // classify: range check on the id, saturate the level
    always_comb
    begin
        new_cmd.op    = op;
        new_cmd.id    = item_id;
        new_cmd.id_ok = (32'(item_id) < 32'(ITEM_COUNT));
        if (32'(level) >= 32'(LEVEL_COUNT))
        begin
            new_cmd.lvl = LVL_W'(LEVEL_COUNT - 1);
        end
        else
        begin
            new_cmd.lvl = level;
        end
    end

    assign busy      = (cnt_reg == 2'd2) || clearing;
    assign push      = start && !busy;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rp_reg];

    always_comb
    begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = cmd_pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg;
        case ({push, cmd_pop})
            2'b10:   cnt_next = cnt_reg + 2'd1;
            2'b01:   cnt_next = cnt_reg - 2'd1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wp_reg] <= new_cmd;
        end
    end

endmodule

/* src/mdwq_back.sv */
module mdwq_back
    import mdwq_pkg::*;
#(
    parameter int ITEM_COUNT  = 256,
    parameter int LEVEL_COUNT = 16
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    input  cmd_t cmd,
    output logic cmd_pop,
    output logic clearing,
    output logic res_valid,
    output res_t res
);

    localparam int IW = (ITEM_COUNT > 1) ? $clog2(ITEM_COUNT) : 1;
    localparam int XW = (IW > ID_W) ? IW : ID_W;
    localparam int LW = (LEVEL_COUNT > 1) ? $clog2(LEVEL_COUNT) : 1;

    typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_EXEC} state_t;

    state_t                 state_reg, state_next;
    logic [IW-1:0]          clr_cnt_reg, clr_cnt_next;
    logic [LEVEL_COUNT-1:0] nonempty_reg, nonempty_next;
    logic                   res_valid_reg, res_valid_next;
    res_t                   res_reg, res_next;

    cmd_t                   cmd_reg;
    logic [IW-1:0]          idx_reg;
    logic [LW-1:0]          lvl_reg;

    logic [IW-1:0]          head_reg [LEVEL_COUNT];
    logic [IW-1:0]          tail_reg [LEVEL_COUNT];

    // {retired, queued}
    logic [1:0]             mark_mem [ITEM_COUNT];
    logic [IW-1:0]          link_mem [ITEM_COUNT];
    logic [1:0]             mark_rd_reg;
    logic [IW-1:0]          link_rd_reg;

    logic [LW-1:0]          low_lvl;
    logic [XW-1:0]          id_x;
    logic [XW-1:0]          idx_x;
    logic [IW-1:0]          rd_idx;
    logic [LW-1:0]          sel_lvl;
    logic                   issue;

    logic                   mark_we;
    logic [IW-1:0]          mark_wa;
    logic [1:0]             mark_wd;
    logic                   link_we;
    logic                   head_we;
    logic [IW-1:0]          head_wd;
    logic                   tail_we;
    logic                   bit_set;
    logic                   single;

    always_comb
    begin
        low_lvl = '0;
        for (int i = LEVEL_COUNT - 1; i >= 0; i--)
        begin
            if (nonempty_reg[i])
            begin
                low_lvl = LW'(i);
            end
        end
    end

    assign id_x    = XW'(cmd.id);
    assign issue   = (state_reg == ST_IDLE) && cmd_valid;
    assign cmd_pop = issue;
    assign sel_lvl = (cmd.op == OP_DEQ) ? low_lvl : cmd.lvl[LW-1:0];
    assign rd_idx  = (cmd.op == OP_DEQ) ? head_reg[low_lvl] : id_x[IW-1:0];

    assign bit_set = nonempty_reg[lvl_reg];
    assign single  = (head_reg[lvl_reg] == tail_reg[lvl_reg]);
    assign idx_x   = XW'(idx_reg);

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        nonempty_next  = nonempty_reg;
        res_valid_next = 1'b0;
        res_next       = res_reg;
        mark_we        = 1'b0;
        mark_wa        = idx_reg;
        mark_wd        = 2'b00;
        link_we        = 1'b0;
        head_we        = 1'b0;
        head_wd        = idx_reg;
        tail_we        = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                mark_we      = 1'b1;
                mark_wa      = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + IW'(1);
                if (clr_cnt_reg == IW'(ITEM_COUNT - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (issue)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next       = ST_IDLE;
                res_valid_next   = 1'b1;
                res_next         = '0;
                case (cmd_reg.op)
                    OP_ENQ:
                    begin
                        if (cmd_reg.id_ok && (mark_rd_reg == 2'b00))
                        begin
                            mark_we           = 1'b1;
                            mark_wd           = 2'b01;
                            tail_we           = 1'b1;
                            res_next.accepted = 1'b1;
                            if (!bit_set)
                            begin
                                head_we                = 1'b1;
                                nonempty_next[lvl_reg] = 1'b1;
                            end
                            else
                            begin
                                link_we = 1'b1;
                            end
                        end
                    end
                    OP_DEQ:
                    begin
                        if (bit_set)
                        begin
                            mark_we           = 1'b1;
                            mark_wd           = {mark_rd_reg[1], 1'b0};
                            res_next.accepted = 1'b1;
                            res_next.item     = idx_x[ID_W-1:0];
                            res_next.retired  = mark_rd_reg[1];
                            if (single)
                            begin
                                nonempty_next[lvl_reg] = 1'b0;
                            end
                            else
                            begin
                                head_we = 1'b1;
                                head_wd = link_rd_reg;
                            end
                        end
                    end
                    OP_MARK:
                    begin
                        if (cmd_reg.id_ok)
                        begin
                            mark_we = 1'b1;
                            mark_wd = {1'b1, mark_rd_reg[0]};
                        end
                    end
                    default:
                    begin
                        res_next.accepted = 1'b0;
                    end
                endcase
                res_next.empty = (nonempty_next == '0);
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            nonempty_reg  <= '0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            nonempty_reg  <= nonempty_next;
            res_valid_reg <= res_valid_next;
            res_reg       <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            cmd_reg <= cmd;
            idx_reg <= rd_idx;
            lvl_reg <= sel_lvl;
        end
        if (head_we)
        begin
            head_reg[lvl_reg] <= head_wd;
        end
        if (tail_we)
        begin
            tail_reg[lvl_reg] <= idx_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mark_we)
        begin
            mark_mem[mark_wa] <= mark_wd;
        end
        if (issue)
        begin
            mark_rd_reg <= mark_mem[rd_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[tail_reg[lvl_reg]] <= idx_reg;
        end
        if (issue)
        begin
            link_rd_reg <= link_mem[rd_idx];
        end
    end

    assign clearing  = (state_reg == ST_CLEAR);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

/* src/multilevel_dedup_work_queue_unit.sv */
// Multilevel deduplicating work queue. One transaction is taken at a clock edge where start is
// high and busy is low; ops are enqueue, dequeue and mark-retired, and every transaction gives
// exactly one result, shown for one cycle with done high. The receiver cannot stall: results
// must be captured on the cycle done is high. The execute unit reads the mark and link
// memories, then writes back, and takes no new transaction until the write back is done; a
// two-entry command queue in front absorbs bursts. With the queue empty, a transaction passes
// through the command queue, the execute registers and the result register before done rises.
// After reset, busy stays high while the mark memory is cleared.
`include "assert_macros.svh"

module multilevel_dedup_work_queue_unit
    import mdwq_pkg::*;
#(
    parameter int ITEM_COUNT  = 256,
    parameter int LEVEL_COUNT = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  op_t              op,
    input  logic [ID_W-1:0]  item_id,
    input  logic [LVL_W-1:0] level,
    output logic             done,
    output logic             accepted,
    output logic [ID_W-1:0]  out_item,
    output logic             out_retired,
    output logic             queue_empty
);

    logic clearing;
    logic cmd_valid;
    logic cmd_pop;
    cmd_t cmd;
    res_t res;

    mdwq_front #(
        .ITEM_COUNT  (ITEM_COUNT),
        .LEVEL_COUNT (LEVEL_COUNT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .op        (op),
        .item_id   (item_id),
        .level     (level),
        .clearing  (clearing),
        .cmd_pop   (cmd_pop),
        .busy      (busy),
        .cmd_valid (cmd_valid),
        .cmd       (cmd)
    );

    mdwq_back #(
        .ITEM_COUNT  (ITEM_COUNT),
        .LEVEL_COUNT (LEVEL_COUNT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .clearing  (clearing),
        .res_valid (done),
        .res       (res)
    );

    assign accepted    = res.accepted;
    assign out_item    = res.item;
    assign out_retired = res.retired;
    assign queue_empty = res.empty;

    `ASSERT_NEXT(a_done_gap, clk, rst_n, done, !done)
    `ASSERT_IMPLIES(a_retired_deq, clk, rst_n, done && out_retired, accepted)
    `ASSERT_IMPLIES(a_item_zero, clk, rst_n, done && !accepted, out_item == '0)
    `ASSERT_IMPLIES(a_clear_busy, clk, rst_n, clearing, busy && !cmd_valid)

endmodule
